### hdl/indexed_min_heap_unit_macros.svh
// Assertion macros shared by the checker of the indexed min-heap unit.
// Depends on nothing. Each use must sit where aclk and aresetn are visible.
`ifndef INDEXED_MIN_HEAP_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IMH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("indexed min-heap check failed");

// Next-cycle implication, checked outside reset.
`define IMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed min-heap check failed");

`endif

### hdl/imh_pkg.sv
// Shared constants, codes and types of the indexed min-heap unit.
// Depends on nothing; used by the controller, the datapath, the top level and the checker.
`default_nettype none
package imh_pkg;
    localparam int CAPACITY   = 128;
    localparam int NUM_IDS    = 1024;
    localparam int KEY_BITS   = 32;
    localparam int ID_BITS    = $clog2(NUM_IDS);
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = 8;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_EXTRACT = 2'd1;
    localparam logic [1:0] FUNC_CHANGE  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam logic [3:0] DP_NOP     = 4'd0;
    localparam logic [3:0] DP_CLEAR   = 4'd1;
    localparam logic [3:0] DP_LOAD    = 4'd2;
    localparam logic [3:0] DP_LOOK    = 4'd3;
    localparam logic [3:0] DP_FAIL    = 4'd4;
    localparam logic [3:0] DP_INS     = 4'd5;
    localparam logic [3:0] DP_EXT     = 4'd6;
    localparam logic [3:0] DP_CHG     = 4'd7;
    localparam logic [3:0] DP_UP_RD   = 4'd8;
    localparam logic [3:0] DP_UP_MOVE = 4'd9;
    localparam logic [3:0] DP_DN_RD   = 4'd10;
    localparam logic [3:0] DP_DN_MOVE = 4'd11;
    localparam logic [3:0] DP_PLACE   = 4'd12;
    localparam logic [3:0] DP_RESULT  = 4'd13;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } heap_ent_t;

    typedef struct packed {
        logic                 held;
        logic [SLOT_BITS-1:0] slot;
    } slot_ent_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       last_one;
        logic       held;
        logic       at_root;
        logic       up_stop;
        logic       no_left;
        logic       down_stop;
        logic       key_lower;
        logic       out_busy;
    } dp_stat_t;
endpackage
`default_nettype wire

### hdl/imh_ctrl.sv
// Controller of the indexed min-heap unit: sequences clear, lookup and sift steps.
// Depends on imh_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none
module imh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire imh_pkg::dp_stat_t stat,
    output imh_pkg::dp_cmd_t       cmd
);
    import imh_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_CHGCMP = 4'd4;
    localparam logic [3:0] S_UP     = 4'd5;
    localparam logic [3:0] S_UPCMP  = 4'd6;
    localparam logic [3:0] S_DN     = 4'd7;
    localparam logic [3:0] S_DNCMP  = 4'd8;
    localparam logic [3:0] S_PLACE  = 4'd9;
    localparam logic [3:0] S_RESP   = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = DP_CLEAR;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_LOAD;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.op     = DP_LOOK;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_RESP;
                priority case (stat.func)
                    FUNC_INSERT: begin
                        if (stat.full) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_FULL;
                        end else if (stat.held) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_ABSENT;
                        end else begin
                            cmd.op     = DP_INS;
                            state_next = S_UP;
                        end
                    end
                    FUNC_EXTRACT: begin
                        if (stat.empty) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.op = DP_EXT;
                            if (!stat.last_one) state_next = S_DN;
                        end
                    end
                    FUNC_CHANGE: begin
                        if (!stat.held) begin
                            cmd.op     = DP_FAIL;
                            cmd.status = ST_ABSENT;
                        end else begin
                            cmd.op     = DP_CHG;
                            state_next = S_CHGCMP;
                        end
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_CHGCMP: begin
                state_next = stat.key_lower ? S_UP : S_DN;
            end
            S_UP: begin
                if (stat.at_root) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = DP_UP_RD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (stat.up_stop) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = DP_UP_MOVE;
                    state_next = S_UP;
                end
            end
            S_DN: begin
                if (stat.no_left) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = DP_DN_RD;
                    state_next = S_DNCMP;
                end
            end
            S_DNCMP: begin
                if (stat.down_stop) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.op     = DP_DN_MOVE;
                    state_next = S_DN;
                end
            end
            S_PLACE: begin
                cmd.op     = DP_PLACE;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!stat.out_busy) begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

### hdl/imh_datapath.sv
// Datapath of the indexed min-heap unit: heap and slot memories, sift registers, result register.
// Depends on imh_pkg; commanded by imh_ctrl.
`default_nettype none
module imh_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire imh_pkg::dp_cmd_t                cmd,
    output imh_pkg::dp_stat_t                    stat,
    input  wire logic [1:0]                      in_func,
    input  wire logic [imh_pkg::ID_BITS-1:0]     in_id,
    input  wire logic [imh_pkg::KEY_BITS-1:0]    in_key,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [imh_pkg::ID_BITS-1:0]          out_id,
    output logic [imh_pkg::KEY_BITS-1:0]         out_key,
    output logic [1:0]                           out_status,
    output logic [imh_pkg::COUNT_BITS-1:0]       out_count
);
    import imh_pkg::*;

    heap_ent_t heap_mem [CAPACITY];
    slot_ent_t slot_mem [NUM_IDS];

    logic [1:0]            func_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [KEY_BITS-1:0]   key_reg;
    heap_ent_t             cur_reg;
    logic [SLOT_BITS-1:0]  pos_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [ID_BITS-1:0]    clr_reg;
    heap_ent_t             rd0_reg, rd1_reg;
    slot_ent_t             slot_rd_reg;
    logic [ID_BITS-1:0]    res_id_reg;
    logic [KEY_BITS-1:0]   res_key_reg;
    logic [1:0]            res_status_reg;
    logic                  valid_reg;
    logic [ID_BITS-1:0]    oid_reg;
    logic [KEY_BITS-1:0]   okey_reg;
    logic [1:0]            ostat_reg;
    logic [COUNT_BITS-1:0] ocount_reg;

    logic [SLOT_BITS-1:0]  pos_m1, parent;
    logic [SLOT_BITS:0]    left;
    logic [SLOT_BITS+1:0]  right;
    logic [COUNT_BITS-1:0] cnt_m1;
    logic                  pick_r;
    heap_ent_t             child;
    logic [SLOT_BITS:0]    child_pos;

    logic [SLOT_BITS-1:0]  ra0, ra1, hwa;
    heap_ent_t             hwd;
    logic                  hwe;
    logic [ID_BITS-1:0]    swa;
    slot_ent_t             swd;
    logic                  swe;

    assign pos_m1    = pos_reg - 1'b1;
    assign parent    = {1'b0, pos_m1[SLOT_BITS-1:1]};
    assign left      = {pos_reg, 1'b1};
    assign right     = {1'b0, left} + 1'b1;
    assign cnt_m1    = count_reg - 1'b1;
    assign pick_r    = (right < {1'b0, count_reg}) && !(rd0_reg.key < rd1_reg.key);
    assign child     = pick_r ? rd1_reg : rd0_reg;
    assign child_pos = pick_r ? right[SLOT_BITS:0] : left;

    always_comb begin
        ra0 = '0;
        ra1 = cnt_m1[SLOT_BITS-1:0];
        hwe = 1'b0;
        hwa = pos_reg;
        hwd = cur_reg;
        swe = 1'b0;
        swa = cur_reg.id;
        swd = '{held: 1'b1, slot: pos_reg};
        unique case (cmd.op)
            DP_CHG:   ra0 = slot_rd_reg.slot;
            DP_UP_RD: ra0 = parent;
            DP_DN_RD: begin
                ra0 = left[SLOT_BITS-1:0];
                ra1 = right[SLOT_BITS-1:0];
            end
            DP_CLEAR: begin
                swe = 1'b1;
                swa = clr_reg;
                swd = '0;
            end
            DP_EXT: begin
                swe = 1'b1;
                swa = rd0_reg.id;
                swd = '0;
            end
            DP_UP_MOVE: begin
                hwe = 1'b1;
                hwd = rd0_reg;
                swe = 1'b1;
                swa = rd0_reg.id;
            end
            DP_DN_MOVE: begin
                hwe = 1'b1;
                hwd = child;
                swe = 1'b1;
                swa = child.id;
            end
            DP_PLACE: begin
                hwe = 1'b1;
                swe = 1'b1;
            end
            default: ra0 = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd0_reg     <= heap_mem[ra0];
        rd1_reg     <= heap_mem[ra1];
        slot_rd_reg <= slot_mem[id_reg];
        if (hwe) heap_mem[hwa] <= hwd;
        if (swe) slot_mem[swa] <= swd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            clr_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (valid_reg && out_ready && (cmd.op != DP_RESULT)) valid_reg <= 1'b0;
            unique case (cmd.op)
                DP_CLEAR: clr_reg <= clr_reg + 1'b1;
                DP_LOAD: begin
                    func_reg       <= in_func;
                    id_reg         <= in_id;
                    key_reg        <= in_key;
                    res_id_reg     <= in_id;
                    res_key_reg    <= in_key;
                    res_status_reg <= ST_OK;
                end
                DP_FAIL: res_status_reg <= cmd.status;
                DP_INS: begin
                    cur_reg   <= '{id: id_reg, key: key_reg};
                    pos_reg   <= count_reg[SLOT_BITS-1:0];
                    count_reg <= count_reg + 1'b1;
                end
                DP_EXT: begin
                    res_id_reg  <= rd0_reg.id;
                    res_key_reg <= rd0_reg.key;
                    cur_reg     <= rd1_reg;
                    pos_reg     <= '0;
                    count_reg   <= cnt_m1;
                end
                DP_CHG: begin
                    cur_reg <= '{id: id_reg, key: key_reg};
                    pos_reg <= slot_rd_reg.slot;
                end
                DP_UP_MOVE: pos_reg <= parent;
                DP_DN_MOVE: pos_reg <= child_pos[SLOT_BITS-1:0];
                DP_RESULT: begin
                    valid_reg  <= 1'b1;
                    oid_reg    <= res_id_reg;
                    okey_reg   <= res_key_reg;
                    ostat_reg  <= res_status_reg;
                    ocount_reg <= count_reg;
                end
                default: pos_reg <= pos_reg;
            endcase
        end
    end

    assign stat.clear_done = (clr_reg == ID_BITS'(NUM_IDS - 1));
    assign stat.func       = func_reg;
    assign stat.full       = (count_reg >= COUNT_BITS'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.last_one   = (count_reg == COUNT_BITS'(1));
    assign stat.held       = slot_rd_reg.held;
    assign stat.at_root    = (pos_reg == '0);
    assign stat.up_stop    = (cur_reg.key >= rd0_reg.key);
    assign stat.no_left    = ({1'b0, left} >= {1'b0, count_reg});
    assign stat.down_stop  = (child.key >= cur_reg.key);
    assign stat.key_lower  = (key_reg < rd0_reg.key);
    assign stat.out_busy   = valid_reg && !out_ready;

    assign out_valid  = valid_reg;
    assign out_id     = oid_reg;
    assign out_key    = okey_reg;
    assign out_status = ostat_reg;
    assign out_count  = ocount_reg;
endmodule
`default_nettype wire

### hdl/indexed_min_heap_unit.sv
// Top level of the indexed min-heap unit: stream ports, controller and datapath.
// Depends on imh_pkg, imh_ctrl and imh_datapath.
//
// Usage: each request on the s_ channel carries an operation in s_tuser (insert,
// extract minimum, change key) and an identifier and key in s_tdata. Every request
// gives exactly one response on the m_ channel with the removed or echoed identifier
// and key, the entry count after the operation, and a status code in m_tuser.
// A full insert, an empty extract and an absent or duplicate identifier are
// reported and leave the heap untouched.
// A sift walks the heap one level at a time. The heap memory's two read ports feed
// one compare per level, and the next level waits on that compare. One request is
// processed at a time: the next one is accepted in the cycle after the response is
// registered. After reset the identifier table is cleared one entry per cycle, with
// s_tready low. A response waits in an output register while m_tready is low; the
// next request is accepted meanwhile, and its own response is held back until the
// previous one has been taken.
`default_nettype none
module indexed_min_heap_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // item_id[9:0], key[41:10], zero fill
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_id[9:0], out_key[41:10], heap_count[49:42]
    output logic [1:0]       m_tuser    // status[1:0]
);
    import imh_pkg::*;

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [ID_BITS-1:0]    o_id;
    logic [KEY_BITS-1:0]   o_key;
    logic [COUNT_BITS-1:0] o_count;

    imh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imh_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_func    (s_tuser),
        .in_id      (s_tdata[ID_BITS-1:0]),
        .in_key     (s_tdata[ID_BITS+KEY_BITS-1:ID_BITS]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_id     (o_id),
        .out_key    (o_key),
        .out_status (m_tuser),
        .out_count  (o_count)
    );

    // Response packing, identifier in the lowest bits.
    assign m_tdata = {6'd0, o_count, o_key, o_id};
endmodule
`default_nettype wire

### hdl/imh_checker.sv
// Port-level checker of the indexed min-heap unit, bound to the top level.
// Depends on imh_pkg and indexed_min_heap_unit_macros.svh.
`default_nettype none
`include "indexed_min_heap_unit_macros.svh"
module imh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import imh_pkg::*;

    // An accepted request keeps the input closed for at least the next cycle.
    `IMH_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)
    // A stalled response holds.
    `IMH_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // The count never exceeds the capacity.
    `IMH_ASSERT_IMPL(a_cap, m_tvalid, m_tdata[49:42] <= 8'(CAPACITY))
    // An empty report comes only with an empty heap.
    `IMH_ASSERT_IMPL(a_empty, m_tvalid && (m_tuser == ST_EMPTY), m_tdata[49:42] == 8'd0)
    // A full report comes only with a full heap.
    `IMH_ASSERT_IMPL(a_full, m_tvalid && (m_tuser == ST_FULL), m_tdata[49:42] == 8'(CAPACITY))
endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (.*);
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench of the indexed min-heap unit: stream requests in, responses checked.
// Depends on imh_pkg and indexed_min_heap_unit; it keeps its own heap model for prediction.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import imh_pkg::*;

    typedef struct packed {
        logic [9:0]  id;
        logic [31:0] key;
        logic [1:0]  status;
        logic [7:0]  count;
    } heap_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    indexed_min_heap_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the heap, kept in step with every accepted request.
    logic [9:0]  shadow_ids  [CAPACITY];
    logic [31:0] shadow_keys [CAPACITY];
    int unsigned shadow_slot [NUM_IDS];
    bit          shadow_held [NUM_IDS];
    int unsigned shadow_count;

    heap_resp_t  pending_resp[$];
    int          error_count;
    int          resp_count;
    int          cycle_count;
    int          stall_hold;     // cycles the response side still holds off
    bit          rx_long_stall;

    function automatic void shadow_place(int unsigned s, logic [9:0] id, logic [31:0] k);
        shadow_ids[s]  = id;
        shadow_keys[s] = k;
        shadow_slot[id] = s;
    endfunction

    function automatic void shadow_rise(int unsigned pos);
        logic [9:0]  id;
        logic [31:0] k;
        int unsigned par;
        id = shadow_ids[pos];
        k  = shadow_keys[pos];
        while (pos > 0) begin
            par = (pos - 1) >> 1;
            if (k >= shadow_keys[par]) break;
            shadow_place(pos, shadow_ids[par], shadow_keys[par]);
            pos = par;
        end
        shadow_place(pos, id, k);
    endfunction

    function automatic void shadow_sink(int unsigned pos);
        logic [9:0]  id;
        logic [31:0] k;
        int unsigned l;
        int unsigned c;
        id = shadow_ids[pos];
        k  = shadow_keys[pos];
        forever begin
            l = 2 * pos + 1;
            if (l >= shadow_count) break;
            // Equal children: the right one is taken.
            if (l + 1 < shadow_count && !(shadow_keys[l] < shadow_keys[l + 1])) c = l + 1;
            else c = l;
            if (shadow_keys[c] >= k) break;
            shadow_place(pos, shadow_ids[c], shadow_keys[c]);
            pos = c;
        end
        shadow_place(pos, id, k);
    endfunction

    // Apply one request to the shadow heap and return the response it must give.
    function automatic heap_resp_t heap_predict(logic [1:0] func, logic [9:0] id,
                                                logic [31:0] k);
        heap_resp_t  r;
        int unsigned s;
        logic [31:0] old;
        r.id = id;
        r.key = k;
        r.status = ST_OK;
        if (func == FUNC_INSERT) begin
            if (shadow_count >= CAPACITY) r.status = ST_FULL;
            else if (shadow_held[id]) r.status = ST_ABSENT;
            else begin
                s = shadow_count;
                shadow_count++;
                shadow_held[id] = 1'b1;
                shadow_place(s, id, k);
                shadow_rise(s);
            end
        end else if (func == FUNC_EXTRACT) begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
                r.id  = shadow_ids[0];
                r.key = shadow_keys[0];
                shadow_held[r.id] = 1'b0;
                shadow_count--;
                if (shadow_count > 0) begin
                    shadow_place(0, shadow_ids[shadow_count], shadow_keys[shadow_count]);
                    shadow_sink(0);
                end
            end
        end else if (func == FUNC_CHANGE) begin
            if (!shadow_held[id] || shadow_slot[id] >= shadow_count) r.status = ST_ABSENT;
            else begin
                s = shadow_slot[id];
                old = shadow_keys[s];
                shadow_keys[s] = k;
                if (k < old) shadow_rise(s);
                else shadow_sink(s);
            end
        end
        r.count = shadow_count[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH response %0d %s: got %0h expected %0h", resp_count, what, got, want);
        error_count++;
    endtask

    // Send one request, optionally after a random wait with valid low. Valid stays high
    // when the next request follows at once; wait_drained drops it.
    task automatic send_request(logic [1:0] func, logic [9:0] id, logic [31:0] k);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, k, id};
        pending_resp.push_back(heap_predict(func, id, k));
        do @(posedge aclk); while (!s_tready);
    endtask

    // Back-to-back variant: valid stays high between requests.
    task automatic send_burst(int n);
        repeat (n) begin
            s_tvalid <= 1'b1;
            s_tuser  <= FUNC_INSERT;
            s_tdata  <= {6'd0, 32'($urandom_range(0, 40)), 10'($urandom_range(0, 1023))};
            #1;
            pending_resp.push_back(heap_predict(s_tuser, s_tdata[9:0], s_tdata[41:10]));
            do @(posedge aclk); while (!s_tready);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_resp.size() != 0);
    endtask

    // Response side: random stalls after each taken response, plus a long hold when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_long_stall) begin
            stall_hold <= 300;
            rx_long_stall <= 1'b0;
            m_tready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            stall_hold <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Response checker.
    always @(posedge aclk) begin
        heap_resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response", m_tdata[9:0], 0);
            end else begin
                want = pending_resp.pop_front();
                if (m_tdata[9:0] !== want.id) report_mismatch("out_id", m_tdata[9:0], want.id);
                if (m_tdata[41:10] !== want.key)
                    report_mismatch("out_key", m_tdata[41:10], want.key);
                if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
                if (m_tdata[49:42] !== want.count)
                    report_mismatch("heap_count", m_tdata[49:42], want.count);
            end
            resp_count++;
        end
    end

    // Watchdog. The slowest run is about 630 requests.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 200000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("indexed_min_heap_unit regression: fail");
            $finish;
        end
    end

    // Directed: empty extract, extreme fields, ties, change up and down, absent ids.
    task automatic test_directed();
        send_request(FUNC_EXTRACT, 10'h3FF, 32'hFFFF_FFFF);   // empty extract echoes
        send_request(FUNC_CHANGE, 10'd5, 32'd1);              // change of absent id
        send_request(FUNC_INSERT, 10'd0, 32'hFFFF_FFFF);
        send_request(FUNC_INSERT, 10'h3FF, 32'd0);
        send_request(FUNC_INSERT, 10'h3FF, 32'd7);            // duplicate insert
        send_request(FUNC_INSERT, 10'h155, 32'h5555_5555);
        send_request(FUNC_INSERT, 10'h2AA, 32'h5555_5555);    // equal keys
        send_request(FUNC_INSERT, 10'd9, 32'h5555_5555);
        send_request(FUNC_CHANGE, 10'd0, 32'd1);              // key falls
        send_request(FUNC_CHANGE, 10'd0, 32'hAAAA_AAAA);      // key rises
        send_request(FUNC_CHANGE, 10'h155, 32'h5555_5555);    // key unchanged
        send_request(2'd3, 10'h1F, 32'h1234_5678);            // unused code is a no-op
        repeat (7) send_request(FUNC_EXTRACT, 10'd0, 32'd0);  // drain past empty
        wait_drained();
    endtask

    // Fill to capacity, try two more, then empty it again.
    task automatic test_full();
        int i;
        for (i = 0; i < CAPACITY; i++) send_request(FUNC_INSERT, 10'(i * 7), $urandom());
        send_request(FUNC_INSERT, 10'd1000, 32'd3);
        send_request(FUNC_INSERT, 10'd0, 32'd3);              // full wins over duplicate
        for (i = 0; i < CAPACITY + 1; i++) send_request(FUNC_EXTRACT, 10'd0, 32'd0);
        wait_drained();
    endtask

    // Long receiver hold while the sender keeps offering.
    task automatic test_backpressure();
        rx_long_stall <= 1'b1;
        send_burst(20);
        wait_drained();
        repeat (30) send_request(FUNC_EXTRACT, 10'd0, 32'd0);
        wait_drained();
    endtask

    // Random mix: key changes mostly on held ids, with small key ranges for ties.
    task automatic test_random(int n);
        int          j;
        int unsigned pick;
        logic [1:0]  func;
        logic [9:0]  id;
        logic [31:0] k;
        for (j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            if (shadow_count > 90) func = (pick < 60) ? FUNC_EXTRACT : FUNC_CHANGE;
            else if (pick < 45) func = FUNC_INSERT;
            else if (pick < 70) func = FUNC_EXTRACT;
            else if (pick < 97) func = FUNC_CHANGE;
            else func = 2'd3;
            if (func == FUNC_CHANGE && shadow_count > 0 && pick % 8 != 0)
                id = shadow_ids[$urandom_range(0, shadow_count - 1)];
            else
                id = $urandom();
            k = (pick % 3 == 0) ? $urandom() : $urandom_range(0, 15);
            send_request(func, id, k);
            if (j == n / 2) wait_drained();   // sender pause until all have come back
        end
        wait_drained();
    endtask

    initial begin
        int i;
        error_count = 0;
        resp_count = 0;
        cycle_count = 0;
        stall_hold = 0;
        shadow_count = 0;
        for (i = 0; i < NUM_IDS; i++) begin
            shadow_held[i] = 1'b0;
            shadow_slot[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full();
        test_backpressure();
        test_random(300);
        repeat (40) @(posedge aclk);
        $display("covered %0d responses: empty, full, duplicate, absent, ties, key changes,",
                 resp_count);
        $display("back-to-back requests under a long response stall and random idling");
        if (error_count == 0 && pending_resp.size() == 0) begin
            $display("indexed_min_heap_unit regression: pass");
        end else begin
            $display("indexed_min_heap_unit regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/imh_pkg.sv
hdl/imh_ctrl.sv
hdl/imh_datapath.sv
hdl/indexed_min_heap_unit.sv
hdl/imh_checker.sv
tb/sv/tb_top.sv
